[sv/lztbe_pkg.sv]
// ----------------------------------------------------------------------------
// lztbe_pkg
// Shared types and constants of the lz token bit encoder: token and code word
// layouts, token opcodes, register indexes and far-offset thresholds.
// ----------------------------------------------------------------------------
package lztbe_pkg;

  // token opcodes
  localparam logic [1:0] OP_LIT   = 2'd0;
  localparam logic [1:0] OP_MATCH = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // code word kinds
  localparam logic KIND_BITS = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  // register indexes, byte address 4*i
  localparam logic [2:0] REG_LEN_LOW  = 3'd0;
  localparam logic [2:0] REG_OFF_LOW  = 3'd1;
  localparam logic [2:0] REG_LEN_EXT  = 3'd2;
  localparam logic [2:0] REG_PFX_MODE = 3'd3;
  localparam logic [2:0] REG_OFF_BIAS = 3'd4;

  // words past this count within one token are dropped
  localparam logic [3:0] MAX_RESULTS = 4'd10;

  // far-offset thresholds for the two prefix styles
  localparam logic [15:0] FAR_SS11 = 16'h0d00;
  localparam logic [15:0] FAR_SS12 = 16'h0500;

  // prefix operand width, 32 bits plus headroom for the ss11 bias
  localparam int PRE_W = 34;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  literal_byte;
    logic [15:0] match_offset;
    logic [15:0] match_length;
  } tok_t;

  typedef struct packed {
    logic        out_kind;
    logic [15:0] out_value;
    logic [4:0]  bit_count;
    logic        last_of_token;
  } code_t;

endpackage

[sv/lz_token_bit_encoder.sv]
// ----------------------------------------------------------------------------
// lz_token_bit_encoder
// Turns parsed LZ tokens into NRV2B-style code bit chunks and raw bytes, one
// code bit per unstalled cycle through a shared bit emitter and prefix unit.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+---------------------------------
//  tok      | in  | tok_valid/tok_ready  | tok_t: opcode, byte, offset, len
//  code     | out | code_valid/code_ready| code_t: kind, value, count, last
//  apb      | in  | psel/penable, pready | 5 registers at 4*i, 32-bit data
//
//  a token steps through its code bit groups (S_BITS, then S_NEXT), its bytes
//  (S_FLUSH_BYTE, S_BYTE, S_NEXT), the close (S_FLUSH_END, S_DONE) and
//  S_IDLE; a prefix adds its search: an msb scan for ss11, or a subtract
//  step per bit pair for ss12.
//  tok_ready is high only between tokens. a held word waits in a one-deep
//  buffer so the last word of a token can be marked; a stalled code channel
//  stalls the sequencer.
//  reset is synchronous, no clearing pass.
//
module lz_token_bit_encoder #(
  parameter int OFFSET_BITS = 16,
  parameter int LENGTH_BITS = 16,
  parameter int CHUNK_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              tok_valid,
  output logic              tok_ready,
  input  lztbe_pkg::tok_t   tok,
  output logic              code_valid,
  input  logic              code_ready,
  output lztbe_pkg::code_t  code,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import lztbe_pkg::*;

  localparam int CL = (CHUNK_BITS > 16) ? 16 : ((CHUNK_BITS < 1) ? 1 : CHUNK_BITS);
  localparam logic [4:0] CL_N = 5'(CL);
  localparam logic [15:0] OFF_MASK =
    (OFFSET_BITS >= 16) ? 16'hffff : 16'((32'd1 << OFFSET_BITS) - 32'd1);
  localparam logic [15:0] LEN_MASK =
    (LENGTH_BITS >= 16) ? 16'hffff : 16'((32'd1 << LENGTH_BITS) - 32'd1);

  // sequencer states
  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_BITS       = 4'd1;
  localparam logic [3:0] S_NEXT       = 4'd2;
  localparam logic [3:0] S_P11_SCAN   = 4'd3;
  localparam logic [3:0] S_P11_EMIT   = 4'd4;
  localparam logic [3:0] S_P12_SUB    = 4'd5;
  localparam logic [3:0] S_P12_EMIT   = 4'd6;
  localparam logic [3:0] S_FLUSH_BYTE = 4'd7;
  localparam logic [3:0] S_BYTE       = 4'd8;
  localparam logic [3:0] S_FLUSH_END  = 4'd9;
  localparam logic [3:0] S_DONE       = 4'd10;

  // what the dispatcher starts next
  localparam logic [2:0] PH_LIT_BYTE = 3'd0;
  localparam logic [2:0] PH_OFF      = 3'd1;
  localparam logic [2:0] PH_OFF_LOW  = 3'd2;
  localparam logic [2:0] PH_LEN      = 3'd3;
  localparam logic [2:0] PH_LEN_PFX  = 3'd4;
  localparam logic [2:0] PH_LEN_EXT  = 3'd5;
  localparam logic [2:0] PH_END      = 3'd6;

  // configuration
  logic [2:0] len_low_bits;
  logic [3:0] off_low_bits;
  logic [2:0] len_ext_bits;
  logic [1:0] prefix_mode;
  logic       off_bias;

  // sequencer and token state
  logic [3:0]       state;
  logic [2:0]       phase;
  logic             is_end;
  logic [7:0]       lit_r;
  logic [15:0]      off_r;
  logic [15:0]      len_r;
  logic [15:0]      prev_off;
  logic             first_pending;
  logic [15:0]      acc;
  logic [4:0]       acc_n;
  logic [7:0]       sreg;
  logic [3:0]       scnt;
  logic [PRE_W-1:0] pi;
  logic [PRE_W-1:0] pt;
  logic [5:0]       pos;
  logic             sub;
  logic [7:0]       bval;
  logic             hold_v;
  code_t            hold;
  logic [3:0]       res_cnt;

  // datapath
  logic [3:0]       off_lowb;
  logic [2:0]       ext_b;
  logic [31:0]      v;
  logic [31:0]      p_off;
  logic [15:0]      thr;
  logic             far;
  logic [17:0]      t;
  logic [17:0]      pow1;
  logic             direct;
  logic [17:0]      e_raw;
  logic [16:0]      e;
  logic [16:0]      e_shift;
  logic [31:0]      pfx_a;
  logic             pfx_ss11;
  logic [PRE_W-1:0] p12_i;
  logic [PRE_W-1:0] p12_t;

  // bit emitter and word push
  logic [3:0]  scnt_m1;
  logic        bit_req;
  logic        bit_val;
  logic [4:0]  acc_inc;
  logic [15:0] acc_sh;
  logic        push_req;
  code_t       push_word;
  logic        keep;
  logic        out_free;
  logic        stall;
  logic        load_code;
  logic        code_valid_next;
  logic [15:0] tok_off;
  logic [15:0] tok_len;

  assign tok_ready = (state == S_IDLE);
  assign pready    = 1'b1;
  assign tok_off   = tok.match_offset & OFF_MASK;
  assign tok_len   = tok.match_length & LEN_MASK;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      len_low_bits <= '0;
      off_low_bits <= '0;
      len_ext_bits <= '0;
      prefix_mode  <= '0;
      off_bias     <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_LEN_LOW:  len_low_bits <= pwdata[2:0];
        REG_OFF_LOW:  off_low_bits <= pwdata[3:0];
        REG_LEN_EXT:  len_ext_bits <= pwdata[2:0];
        REG_PFX_MODE: prefix_mode  <= pwdata[1:0];
        REG_OFF_BIAS: off_bias     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_LEN_LOW:  prdata = {29'd0, len_low_bits};
      REG_OFF_LOW:  prdata = {28'd0, off_low_bits};
      REG_LEN_EXT:  prdata = {29'd0, len_ext_bits};
      REG_PFX_MODE: prdata = {30'd0, prefix_mode};
      REG_OFF_BIAS: prdata = {31'd0, off_bias};
      default:      prdata = 32'd0;
    endcase
  end

  // -------------------------------------------------------------- datapath
  always_comb begin
    off_lowb = (off_low_bits > 4'd8) ? 4'd8 : off_low_bits;
    ext_b    = (len_ext_bits > 3'd4) ? 3'd4 : len_ext_bits;
    v        = {16'd0, off_r} - {31'd0, off_bias};
    p_off    = 32'd1 + (v >> off_lowb);
    thr      = prefix_mode[0] ? FAR_SS11 : FAR_SS12;
    far      = (off_r > thr);
    t        = {2'd0, len_r} - 18'd1 - {17'd0, far};
    pow1     = 18'd1 << len_low_bits;
    direct   = (len_low_bits != 3'd0) && ($signed(t) < $signed(pow1));
    e_raw    = t - pow1;
    e        = e_raw[17] ? 17'd0 : e_raw[16:0];
    e_shift  = e >> ext_b;
    pfx_a    = (phase == PH_LEN_PFX) ? {15'd0, e_shift} : p_off;
    pfx_ss11 = (phase == PH_LEN_PFX) ? prefix_mode[1] : prefix_mode[0];
    p12_i    = pi - pt;
    p12_t    = pt << 2;
  end

  // --------------------------------------------------- bit emitter / push
  always_comb begin
    scnt_m1 = scnt - 4'd1;
    bit_req = 1'b0;
    bit_val = 1'b0;
    case (state)
      S_BITS: begin
        bit_req = (scnt != 4'd0);
        bit_val = sreg[scnt_m1[2:0]];
      end
      S_P11_EMIT, S_P12_EMIT: begin
        bit_req = 1'b1;
        bit_val = sub ? 1'b0 : pi[pos];
      end
      default: ;
    endcase

    acc_inc   = acc_n + 5'd1;
    acc_sh    = {acc[14:0], bit_val};
    push_req  = 1'b0;
    push_word = '{out_kind: KIND_BITS, out_value: acc, bit_count: acc_n,
                  last_of_token: 1'b0};
    if (bit_req && (acc_inc >= CL_N)) begin
      push_req            = 1'b1;
      push_word.out_value = acc_sh;
      push_word.bit_count = acc_inc;
    end
    case (state)
      S_FLUSH_BYTE, S_FLUSH_END: push_req = (acc_n != 5'd0);
      S_BYTE: begin
        push_req  = 1'b1;
        push_word = '{out_kind: KIND_BYTE, out_value: {8'd0, bval}, bit_count: 5'd0,
                      last_of_token: 1'b0};
      end
      default: ;
    endcase

    keep      = (res_cnt < MAX_RESULTS);
    out_free  = !code_valid || code_ready;
    stall     = (push_req && keep && hold_v && !out_free) ||
                ((state == S_DONE) && hold_v && !out_free);
    load_code = !stall && hold_v && ((push_req && keep) || (state == S_DONE));
    code_valid_next = load_code ? 1'b1 : (code_ready ? 1'b0 : code_valid);
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else begin
      code_valid <= code_valid_next;
    end
    if (load_code) begin
      code <= {hold.out_kind, hold.out_value, hold.bit_count, (state == S_DONE)};
    end
  end

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_END;
      is_end        <= 1'b0;
      prev_off      <= 16'd1;
      first_pending <= 1'b1;
      acc           <= '0;
      acc_n         <= '0;
      scnt          <= '0;
      sub           <= 1'b0;
      hold_v        <= 1'b0;
      res_cnt       <= '0;
    end else if (!stall) begin
      if (bit_req) begin
        if (acc_inc >= CL_N) begin
          acc   <= '0;
          acc_n <= '0;
        end else begin
          acc   <= acc_sh;
          acc_n <= acc_inc;
        end
      end
      if (push_req && keep) begin
        hold    <= push_word;
        hold_v  <= 1'b1;
        res_cnt <= res_cnt + 4'd1;
      end

      case (state)
        S_IDLE: begin
          if (tok_valid) begin
            acc     <= '0;
            acc_n   <= '0;
            res_cnt <= '0;
            lit_r   <= tok.literal_byte;
            // the end marker codes offset zero
            off_r   <= (tok.opcode == OP_END) ? 16'd0 : tok_off;
            len_r   <= tok_len;
            is_end  <= (tok.opcode == OP_END);
            case (tok.opcode)
              OP_LIT: begin
                if (first_pending) begin
                  // first literal of a stream goes out bare
                  first_pending <= 1'b0;
                  bval          <= tok.literal_byte;
                  phase         <= PH_END;
                  state         <= S_FLUSH_BYTE;
                end else begin
                  sreg  <= 8'd1;
                  scnt  <= 4'd1;
                  phase <= PH_LIT_BYTE;
                  state <= S_BITS;
                end
              end
              OP_MATCH: begin
                if (tok_off == prev_off) begin
                  // match flag then repeat-offset code 01
                  sreg  <= 8'd1;
                  scnt  <= 4'd3;
                  phase <= PH_LEN;
                end else begin
                  prev_off <= tok_off;
                  sreg     <= 8'd0;
                  scnt     <= 4'd1;
                  phase    <= PH_OFF;
                end
                state <= S_BITS;
              end
              OP_END: begin
                prev_off      <= 16'd1;
                first_pending <= 1'b1;
                sreg          <= 8'd0;
                scnt          <= 4'd1;
                phase         <= PH_OFF;
                state         <= S_BITS;
              end
              default: ;
            endcase
          end
        end

        S_BITS: begin
          if (scnt == 4'd0) begin
            state <= S_NEXT;
          end else begin
            scnt <= scnt_m1;
          end
        end

        S_NEXT: begin
          case (phase)
            PH_LIT_BYTE: begin
              bval  <= lit_r;
              phase <= PH_END;
              state <= S_FLUSH_BYTE;
            end
            PH_OFF, PH_LEN_PFX: begin
              phase <= (phase == PH_OFF) ? PH_OFF_LOW : PH_LEN_EXT;
              if (pfx_a < 32'd2) begin
                sreg  <= {6'd0, pfx_a[0], 1'b1};
                scnt  <= 4'd2;
                state <= S_BITS;
              end else if (pfx_ss11) begin
                pi    <= {2'd0, pfx_a} + 34'd2;
                pos   <= 6'(PRE_W - 1);
                state <= S_P11_SCAN;
              end else begin
                pi    <= {2'd0, pfx_a};
                pt    <= 34'd2;
                pos   <= 6'd1;
                state <= S_P12_SUB;
              end
            end
            PH_OFF_LOW: begin
              phase <= is_end ? PH_END : PH_LEN;
              if (off_lowb == 4'd8) begin
                bval  <= v[7:0];
                state <= S_FLUSH_BYTE;
              end else begin
                sreg  <= v[7:0];
                scnt  <= off_lowb;
                state <= S_BITS;
              end
            end
            PH_LEN: begin
              sreg  <= direct ? t[7:0] : 8'd0;
              scnt  <= {1'b0, len_low_bits};
              phase <= direct ? PH_END : PH_LEN_PFX;
              state <= S_BITS;
            end
            PH_LEN_EXT: begin
              sreg  <= e[7:0];
              scnt  <= {1'b0, ext_b};
              phase <= PH_END;
              state <= S_BITS;
            end
            default: state <= S_FLUSH_END;
          endcase
        end

        // msb search, one bit a cycle
        S_P11_SCAN: begin
          pos <= pos - 6'd1;
          if (pi[pos]) begin
            sub   <= 1'b0;
            state <= S_P11_EMIT;
          end
        end

        // each bit below the msb, then a continue zero
        S_P11_EMIT: begin
          if (!sub) begin
            sub <= 1'b1;
          end else begin
            sub <= 1'b0;
            if (pos == 6'd1) begin
              sreg  <= {6'd0, pi[0], 1'b1};
              scnt  <= 4'd2;
              state <= S_BITS;
            end else begin
              pos <= pos - 6'd1;
            end
          end
        end

        // strip the 2, 8, 32 ... bias, pos tracks log2 of pt
        S_P12_SUB: begin
          pi <= p12_i;
          pt <= p12_t;
          if (p12_i < p12_t) begin
            pos   <= pos + 6'd1;
            sub   <= 1'b0;
            state <= S_P12_EMIT;
          end else begin
            pos <= pos + 6'd2;
          end
        end

        // bit pairs, continue zero after each even position
        S_P12_EMIT: begin
          if (sub) begin
            sub <= 1'b0;
            pos <= pos - 6'd1;
          end else if (!pos[0]) begin
            sub <= 1'b1;
          end else if (pos == 6'd1) begin
            sreg  <= {6'd0, pi[0], 1'b1};
            scnt  <= 4'd2;
            state <= S_BITS;
          end else begin
            pos <= pos - 6'd1;
          end
        end

        S_FLUSH_BYTE: begin
          acc   <= '0;
          acc_n <= '0;
          state <= S_BYTE;
        end

        S_BYTE: state <= S_NEXT;

        S_FLUSH_END: begin
          acc   <= '0;
          acc_n <= '0;
          state <= S_DONE;
        end

        S_DONE: begin
          hold_v <= 1'b0;
          state  <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // ------------------------------------------------------------ assertions
  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !hold_v)
    else $error("word left in hold buffer between tokens");

  a_acc_below_chunk: assert property (@(posedge clk) disable iff (rst)
    acc_n < CL_N)
    else $error("chunk accumulator overfilled");

  a_res_cap: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= MAX_RESULTS)
    else $error("word count beyond limit");

  a_token_starts: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && tok_ready &&
     (tok.opcode == OP_LIT || tok.opcode == OP_MATCH || tok.opcode == OP_END))
    |=> (state != S_IDLE))
    else $error("accepted token did not start the sequencer");

endmodule
